@@ hdl/deq_pkg.sv @@
// Shared types and codes of the double-ended queue core.
package deq_pkg;

  // Fixed field widths of the request and result items
  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // Operation codes carried in the request
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_PEEK_FRONT = 3'd4,
    FUNC_PEEK_BACK  = 3'd5,
    FUNC_SEARCH     = 3'd6
  } func_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT
  } state_t;

  // Store read address source
  typedef enum logic [1:0] {
    RD_FRONT,
    RD_BACK,
    RD_SCAN
  } rd_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;        // capture the request
    rd_sel_t rd_sel;      // read address for this cycle
    logic    push_front;
    logic    push_back;
    logic    pop_front;
    logic    pop_back;
    logic    set_res;     // set result without data
    status_t res_status;
    logic    res_found;
    logic    take_data;   // result ok, data from the store read
    logic    scan_start;
    logic    scan_step;
    logic    emit;        // load the output register
  } deq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    func_t op;
    logic  full;
    logic  empty;
    logic  match;
    logic  scan_last;
    logic  out_free;
  } deq_stat_t;

endpackage

@@ hdl/deq_ctrl.sv @@
// Controller state machine of the double-ended queue core.
module deq_ctrl
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  deq_stat_t stat,
  output deq_cmd_t  cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    cmd.rd_sel = RD_FRONT;
    cmd.res_status = STAT_OK;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_EMIT;
        unique case (stat.op) inside
          FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
            cmd.set_res = 1'b1;
            if (stat.full) begin
              cmd.res_status = STAT_FULL;
            end else if (stat.op == FUNC_PUSH_FRONT) begin
              cmd.push_front = 1'b1;
            end else begin
              cmd.push_back = 1'b1;
            end
          end
          FUNC_POP_FRONT, FUNC_POP_BACK, FUNC_PEEK_FRONT, FUNC_PEEK_BACK: begin
            if (stat.empty) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = STAT_EMPTY;
            end else begin
              // read issued now, data ready in the fetch state
              cmd.rd_sel = (stat.op == FUNC_POP_BACK || stat.op == FUNC_PEEK_BACK) ?
                           RD_BACK : RD_FRONT;
              state_next = ST_FETCH;
            end
          end
          FUNC_SEARCH: begin
            if (stat.empty) begin
              cmd.set_res = 1'b1;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN_RD;
            end
          end
          default: begin
            cmd.set_res = 1'b1;
          end
        endcase
      end
      ST_FETCH: begin
        cmd.take_data = 1'b1;
        cmd.pop_front = (stat.op == FUNC_POP_FRONT);
        cmd.pop_back  = (stat.op == FUNC_POP_BACK);
        state_next    = ST_EMIT;
      end
      ST_SCAN_RD: begin
        cmd.rd_sel = RD_SCAN;
        state_next = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (stat.match) begin
          cmd.set_res   = 1'b1;
          cmd.res_found = 1'b1;
          state_next    = ST_EMIT;
        end else if (stat.scan_last) begin
          cmd.set_res = 1'b1;
          state_next  = ST_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
          state_next    = ST_SCAN_RD;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/deq_dp.sv @@
// Datapath of the double-ended queue core: ring store, indices and result register.
module deq_dp
  import deq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = $clog2(DEPTH + 1),
  parameter int OUT_W      = ((STATUS_W + VALUE_W + CNT_W + 2 + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  func_t                     in_func,
  input  logic signed [VALUE_W-1:0] in_value,
  input  deq_cmd_t                  cmd,
  output deq_stat_t                 stat,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_W-1:0]          m_tdata
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_q;
  logic signed [DATA_WIDTH-1:0] val_q;
  func_t                        op_q;
  logic [IDX_W-1:0]             front, back, scan_ptr;
  logic [CNT_W-1:0]             cnt, scan_k;
  logic [IDX_W-1:0]             rd_addr, wr_addr;
  logic                         wr_en;
  status_t                      res_status;
  logic signed [VALUE_W-1:0]    res_data;
  logic                         res_found;
  logic signed [VALUE_W-1:0]    rd_word;

  // Stored word presented in the 32-bit data field
  assign rd_word = VALUE_W'(rd_q);

  // Request capture; value kept in the stored word width
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_func;
      val_q <= DATA_WIDTH'(in_value);
    end
  end

  // Store address selection
  always_comb begin
    unique case (cmd.rd_sel)
      RD_FRONT: rd_addr = front;
      RD_BACK:  rd_addr = idx_dec(back);
      RD_SCAN:  rd_addr = scan_ptr;
      default:  rd_addr = front;
    endcase
    wr_en   = cmd.push_front | cmd.push_back;
    wr_addr = cmd.push_front ? idx_dec(front) : back;
  end

  // Ring store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= val_q;
    end
    rd_q <= mem[rd_addr];
  end

  // Front, back and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      cnt   <= '0;
    end else begin
      if (cmd.push_front) begin
        front <= idx_dec(front);
      end else if (cmd.pop_front) begin
        front <= idx_inc(front);
      end
      if (cmd.push_back) begin
        back <= idx_inc(back);
      end else if (cmd.pop_back) begin
        back <= idx_dec(back);
      end
      if (cmd.push_front || cmd.push_back) begin
        cnt <= cnt + 1'b1;
      end else if (cmd.pop_front || cmd.pop_back) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Search walk from front to back
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_ptr <= front;
      scan_k   <= '0;
    end else if (cmd.scan_step) begin
      scan_ptr <= idx_inc(scan_ptr);
      scan_k   <= scan_k + 1'b1;
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (cmd.take_data) begin
      res_status <= STAT_OK;
      res_data   <= rd_word;
      res_found  <= 1'b0;
    end else if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_data   <= '0;
      res_found  <= cmd.res_found;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= OUT_W'({(cnt == '0), cnt, res_found, res_data, res_status});
    end
  end

  // Status to the controller
  assign stat.op        = op_q;
  assign stat.full      = (cnt == CNT_W'(DEPTH));
  assign stat.empty     = (cnt == '0);
  assign stat.match     = (rd_q == val_q);
  assign stat.scan_last = ((scan_k + 1'b1) == cnt);
  assign stat.out_free  = ~m_tvalid | m_tready;

endmodule

@@ hdl/double_ended_queue_core.sv @@
// Top level of the double-ended queue core.
//
// A bounded double-ended queue of DEPTH words of DATA_WIDTH bits in a ring store.
// Slave channel: one request per item, an operation code and a value.
// Master channel: one result per request with status, data, found flag,
// fill count and empty flag.
// Sequence: the controller takes one request at a time. Push, failing operations
// and the unused code pass through the execute and emit states; pop and peek
// add a fetch state for the registered store read. A search of a non-empty queue
// walks the entries from the front until a hit or the end, at most DEPTH of them;
// each entry costs a store read state and a compare state.
// The result enters the output register as the controller returns to idle.
// Reset empties the queue (indices and count cleared); store contents are not
// cleared and are never used before being written.
// When the receiver stalls, the result waits in the output register; the next
// request is still taken and worked up to its result, which then waits until
// the output register frees.
module double_ended_queue_core
  import deq_pkg::*;
#(
  parameter int  DEPTH      = 16,
  parameter int  DATA_WIDTH = 32,
  localparam int CNT_W      = $clog2(DEPTH + 1),
  localparam int IN_W       = ((FUNC_W + VALUE_W + 7) / 8) * 8,
  localparam int OUT_W      = ((STATUS_W + VALUE_W + CNT_W + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // func[2:0], value[34:3]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // status, data, found, count, is_empty
);

  deq_cmd_t  cmd;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  deq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W),
    .OUT_W      (OUT_W)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_func  (func_t'(s_tdata[FUNC_W-1:0])),
    .in_value (s_tdata[FUNC_W+VALUE_W-1:FUNC_W]),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the double-ended queue core: random and directed requests.
`timescale 1ns / 1ps

module tb
  import deq_pkg::*;
();

  localparam int DEPTH       = 16;
  localparam int CNT_W       = 5;
  localparam int IN_W        = ((FUNC_W + VALUE_W + 7) / 8) * 8;
  localparam int OUT_W       = ((STATUS_W + VALUE_W + CNT_W + 2 + 7) / 8) * 8;
  localparam int DATA_LSB    = STATUS_W;
  localparam int FOUND_BIT   = STATUS_W + VALUE_W;
  localparam int COUNT_LSB   = FOUND_BIT + 1;
  localparam int EMPTY_BIT   = COUNT_LSB + CNT_W;
  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_AT     = 200;   // result count at which the long sink stall starts
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 2000;
  localparam int MAX_SHOWN   = 10;

  // code with no operation behind it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

  localparam logic [VALUE_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] WORD_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] data;
    logic               found;
    logic [CNT_W-1:0]   count;
    logic               is_empty;
  } deq_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  // requests still to be offered, results still awaited
  logic [IN_W-1:0] request_q[$];
  deq_result_t     result_q[$];

  // shadow of the queue contents
  logic [VALUE_W-1:0] slots[DEPTH];
  logic [3:0]         front_ptr = '0;
  logic [3:0]         back_ptr = '0;
  logic [CNT_W-1:0]   stored_n = '0;

  int   mismatches = 0;
  int   results_checked = 0;
  int   gap_left = 0;
  int   recv_left = 0;
  int   hold_left = 0;
  int   idle_cycles = 0;
  logic hold_done = 1'b0;
  logic send_eager = 1'b0;
  logic recv_eager = 1'b0;

  double_ended_queue_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one operation to the shadow queue and return what the core should report
  function automatic deq_result_t apply_deque_op(logic [FUNC_W-1:0] code,
                                                 logic [VALUE_W-1:0] word);
    deq_result_t r;
    logic [3:0]  p;
    int          k;
    r = '{status: STAT_OK, data: '0, found: 1'b0, count: '0, is_empty: 1'b0};
    case (code) inside
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (stored_n == DEPTH) begin
          r.status = STAT_FULL;
        end else if (code == FUNC_PUSH_FRONT) begin
          front_ptr = front_ptr - 4'd1;
          slots[front_ptr] = word;
          stored_n = stored_n + 1'b1;
        end else begin
          slots[back_ptr] = word;
          back_ptr = back_ptr + 4'd1;
          stored_n = stored_n + 1'b1;
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK, FUNC_PEEK_FRONT, FUNC_PEEK_BACK: begin
        if (stored_n == 0) begin
          r.status = STAT_EMPTY;
        end else if (code == FUNC_POP_FRONT) begin
          r.data = slots[front_ptr];
          front_ptr = front_ptr + 4'd1;
          stored_n = stored_n - 1'b1;
        end else if (code == FUNC_POP_BACK) begin
          back_ptr = back_ptr - 4'd1;
          r.data = slots[back_ptr];
          stored_n = stored_n - 1'b1;
        end else if (code == FUNC_PEEK_FRONT) begin
          r.data = slots[front_ptr];
        end else begin
          r.data = slots[back_ptr - 4'd1];
        end
      end
      FUNC_SEARCH: begin
        p = front_ptr;
        for (k = 0; k < stored_n; k++) begin
          if (slots[p] == word) r.found = 1'b1;
          p = p + 4'd1;
        end
      end
      default: ;
    endcase
    r.count    = stored_n;
    r.is_empty = (stored_n == 0);
    return r;
  endfunction

  task automatic queue_request(input logic [FUNC_W-1:0] code, input logic [VALUE_W-1:0] word);
    request_q.push_back({{(IN_W - FUNC_W - VALUE_W){1'b0}}, word, code});
  endtask

  // Request driver: takes requests from the pending queue, with random gaps
  always @(posedge clk) begin : drive_requests
    logic taken;
    taken = s_tvalid && s_tready;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (taken) begin
        result_q.push_back(apply_deque_op(s_tdata[FUNC_W-1:0], s_tdata[FUNC_W +: VALUE_W]));
      end
      if (!s_tvalid || taken) begin
        if (gap_left != 0) begin
          s_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (request_q.size() != 0) begin
          s_tdata  <= request_q.pop_front();
          s_tvalid <= 1'b1;
          gap_left <= send_eager ? 0 : $urandom_range(0, 19);
          if ($urandom_range(0, 39) == 0) send_eager <= !send_eager;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result and paces tready, with one long stall
  always @(posedge clk) begin : check_results
    deq_result_t want;
    deq_result_t got;
    logic        taken;
    int          pause;
    taken = m_tvalid && m_tready;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (taken) begin
        got.status   = status_t'(m_tdata[STATUS_W-1:0]);
        got.data     = m_tdata[DATA_LSB +: VALUE_W];
        got.found    = m_tdata[FOUND_BIT];
        got.count    = m_tdata[COUNT_LSB +: CNT_W];
        got.is_empty = m_tdata[EMPTY_BIT];
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result %0d arrived with none outstanding: status=%0d data=%h",
                     results_checked, got.status, got.data);
        end else begin
          want = result_q.pop_front();
          if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display({"result %0d mismatch: exp st=%0d data=%h found=%b cnt=%0d empty=%b,",
                        " got st=%0d data=%h found=%b cnt=%0d empty=%b"},
                       results_checked, want.status, want.data, want.found, want.count,
                       want.is_empty, got.status, got.data, got.found, got.count,
                       got.is_empty);
          end
        end
        results_checked <= results_checked + 1;
      end

      if (taken && results_checked + 1 == HOLD_AT && !hold_done) begin
        // long sink stall so the core backs up and stops taking requests
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        m_tready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= (hold_left == 1);
      end else if (taken) begin
        pause = recv_eager ? 0 : $urandom_range(0, 19);
        recv_left <= pause;
        m_tready  <= (pause == 0);
        if ($urandom_range(0, 39) == 0) recv_eager <= !recv_eager;
      end else if (recv_left != 0) begin
        recv_left <= recv_left - 1;
        m_tready  <= (recv_left == 1);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    logic [VALUE_W-1:0] recent[16];
    logic [3:0]         recent_wr;
    logic [VALUE_W-1:0] word;
    logic [FUNC_W-1:0]  code;
    int                 n;
    int                 roll;
    int                 burst_left;
    int                 push_pct;

    for (n = 0; n < 16; n++) recent[n] = '0;
    recent_wr  = '0;
    burst_left = 0;
    push_pct   = 50;

    // empty queue: every failing read, search and the unused code
    queue_request(FUNC_POP_FRONT, 32'h0);
    queue_request(FUNC_POP_BACK, 32'h0);
    queue_request(FUNC_PEEK_FRONT, 32'h0);
    queue_request(FUNC_PEEK_BACK, 32'h0);
    queue_request(FUNC_SEARCH, 32'h0);
    queue_request(FUNC_UNUSED, 32'hFFFF_FFFF);
    // extremes at both ends, then search hit and miss
    queue_request(FUNC_PUSH_FRONT, WORD_MIN);
    queue_request(FUNC_PUSH_BACK, WORD_MAX);
    queue_request(FUNC_SEARCH, WORD_MAX);
    queue_request(FUNC_SEARCH, 32'h1234_5678);
    // fill up, alternating ends, walking bit patterns
    for (n = 0; n < DEPTH - 2; n++) begin
      word = (32'h1 << (2 * n + 1)) ^ ((n % 2) ? 32'hFFFF_FFFF : 32'h0);
      queue_request((n % 2) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, word);
    end
    // full queue: both pushes refused
    queue_request(FUNC_PUSH_FRONT, 32'h0);
    queue_request(FUNC_PUSH_BACK, 32'hFFFF_FFFF);
    queue_request(FUNC_SEARCH, 32'h1 << 9);
    queue_request(FUNC_POP_FRONT, 32'h0);
    queue_request(FUNC_POP_BACK, 32'h0);

    // random part in bursts that lean towards filling or draining, or stay balanced
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(10, 40);
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      burst_left--;

      case ($urandom_range(0, 24))
        0:       word = WORD_MIN;
        1:       word = WORD_MAX;
        2:       word = 32'h0;
        3:       word = 32'hFFFF_FFFF;
        default: word = $urandom;
      endcase

      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        code = FUNC_UNUSED;
      end else if (roll < 14) begin
        code = FUNC_SEARCH;
        if ($urandom_range(0, 1)) word = recent[$urandom_range(0, 15)];
      end else if (roll < 26) begin
        code = $urandom_range(0, 1) ? FUNC_PEEK_FRONT : FUNC_PEEK_BACK;
      end else if ($urandom_range(0, 99) < push_pct) begin
        code = $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
        recent[recent_wr] = word;
        recent_wr = recent_wr + 4'd1;
      end else begin
        code = $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
      end
      queue_request(code, word);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || s_tvalid) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (mismatches == 0 && result_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/deq_pkg.sv
hdl/deq_ctrl.sv
hdl/deq_dp.sv
hdl/double_ended_queue_core.sv
tb/tb.sv
